// File: hdl/moap_pkg.sv
// Package for the multiply-with-carry generator with ranged draws.
// Holds the constants, the command codes and the controller/datapath types.
// No dependencies.
package moap_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned NUM_HIST = 4;
  localparam int unsigned NUM_WORDS = NUM_HIST + 1;
  localparam int unsigned IDX_W    = $clog2(NUM_WORDS);
  localparam int unsigned CARRY_IDX = NUM_HIST;
  localparam int unsigned DISCARDS = 19;
  localparam int unsigned DISC_W   = $clog2(DISCARDS);

  localparam logic [WORD_W-1:0] SEED_MULT = 32'd29943829;
  localparam logic [WORD_W-1:0] MWC_A3    = 32'd2111111111;
  localparam logic [WORD_W-1:0] MWC_A2    = 32'd1492;
  localparam logic [WORD_W-1:0] MWC_A1    = 32'd1776;
  localparam logic [WORD_W-1:0] MWC_A0    = 32'd5115;
  localparam logic [WORD_W-1:0] RANGE_ERR_VALUE = 32'h8000_0000;

  localparam logic [1:0] CMD_SEED  = 2'd0;
  localparam logic [1:0] CMD_RAW   = 2'd1;
  localparam logic [1:0] CMD_RANGE = 2'd2;

  typedef enum logic [3:0] {
    S_BOOT,
    S_IDLE,
    S_SEED_MUL,
    S_SEED_WR,
    S_ADV_M3,
    S_ADV_M2,
    S_ADV_M1,
    S_ADV_M0,
    S_ADV_COMMIT,
    S_RNG_MUL,
    S_FINISH
  } state_t;

  typedef enum logic [1:0] {
    MODE_SEED,
    MODE_RAW,
    MODE_RANGE
  } mode_t;

  typedef enum logic [2:0] {
    MUL_W3,
    MUL_W2,
    MUL_W1,
    MUL_W0,
    MUL_SEED,
    MUL_RANGE
  } mul_sel_t;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_LOW,
    RES_ERR,
    RES_SCALED
  } res_sel_t;

  typedef struct packed {
    logic             load;
    logic             seed_clr;
    logic             mul_en;
    mul_sel_t         mul_sel;
    logic             acc_init;
    logic             acc_add;
    logic             seed_wr;
    logic [IDX_W-1:0] seed_idx;
    logic             advance;
    logic             out_load;
    res_sel_t         res_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] command;
    logic       hi_eq_lo;
    logic       hi_lt_lo;
    logic       out_room;
  } dp_stat_t;

endpackage

// File: hdl/moap_req_if.sv
// Request channel of the generator: command word with seed and range bounds.
// Depends on moap_pkg.
interface moap_req_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        command;
  logic signed [moap_pkg::WORD_W-1:0] seed_value;
  logic signed [moap_pkg::WORD_W-1:0] range_low;
  logic signed [moap_pkg::WORD_W-1:0] range_high;

  modport source (output valid, command, seed_value, range_low, range_high, input ready);
  modport sink (input valid, command, seed_value, range_low, range_high, output ready);
endinterface

// File: hdl/moap_rsp_if.sv
// Response channel of the generator: raw word, ranged value and error flag.
// Depends on moap_pkg.
interface moap_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [moap_pkg::WORD_W-1:0]        raw_word;
  logic signed [moap_pkg::WORD_W-1:0] ranged_value;
  logic                              range_error;

  modport source (output valid, raw_word, ranged_value, range_error, input ready);
  modport sink (input valid, raw_word, ranged_value, range_error, output ready);
endinterface

// File: hdl/mother_of_all_prng_with_range_core.sv
// Multiply-with-carry generator with ranged draws: four 32-bit history words
// and a carry, advanced by one shared 32x32 multiplier and a 64-bit accumulator.
// A raw draw runs one advance from acceptance to result and a ranged draw adds a
// scaling multiply; each advance runs four multiply-accumulate steps and a commit
// through the one multiplier. An empty or inverted range, or command code 3, goes
// straight to the result. A reseed writes five seed-chain words, each a multiply
// and a write, then runs 19 discarded advances. After reset the block seeds itself
// with zero and takes no request meanwhile. One request is in flight at a time; a
// finished word waits in the output register while the next request is accepted.
module mother_of_all_prng_with_range_core (
  input  logic       clk,
  input  logic       rst,
  moap_req_if.sink   req,
  moap_rsp_if.source rsp
);
  import moap_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     in_ready;

  assign req.ready = in_ready;

  moap_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  moap_dp u_dp (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .rsp  (rsp),
    .cmd  (cmd),
    .stat (stat)
  );

endmodule

// File: hdl/moap_ctrl.sv
// Controller of the generator: sequences seeding, advances and ranged draws.
// Depends on moap_pkg; drives the datapath through dp_cmd_t.
module moap_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  moap_pkg::dp_stat_t stat,
  output moap_pkg::dp_cmd_t  cmd
);
  import moap_pkg::*;

  state_t            state, state_next;
  mode_t             mode, mode_next;
  res_sel_t          res_sel, res_sel_next;
  logic [IDX_W-1:0]  idx, idx_next;
  logic [DISC_W-1:0] disc, disc_next;
  logic              boot, boot_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_BOOT;
      mode    <= MODE_SEED;
      res_sel <= RES_ZERO;
      idx     <= '0;
      disc    <= '0;
      boot    <= 1'b1;
    end else begin
      state   <= state_next;
      mode    <= mode_next;
      res_sel <= res_sel_next;
      idx     <= idx_next;
      disc    <= disc_next;
      boot    <= boot_next;
    end
  end

  always_comb begin
    state_next   = state;
    mode_next    = mode;
    res_sel_next = res_sel;
    idx_next     = idx;
    disc_next    = disc;
    boot_next    = boot;
    in_ready     = 1'b0;
    cmd.load     = 1'b0;
    cmd.seed_clr = 1'b0;
    cmd.mul_en   = 1'b0;
    cmd.mul_sel  = MUL_W3;
    cmd.acc_init = 1'b0;
    cmd.acc_add  = 1'b0;
    cmd.seed_wr  = 1'b0;
    cmd.seed_idx = idx;
    cmd.advance  = 1'b0;
    cmd.out_load = 1'b0;
    cmd.res_sel  = res_sel;
    case (state)
      S_BOOT: begin
        cmd.seed_clr = 1'b1;
        mode_next    = MODE_SEED;
        idx_next     = '0;
        disc_next    = '0;
        state_next   = S_SEED_MUL;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load     = 1'b1;
          res_sel_next = RES_ZERO;
          case (stat.command)
            CMD_SEED: begin
              mode_next  = MODE_SEED;
              idx_next   = '0;
              disc_next  = '0;
              state_next = S_SEED_MUL;
            end
            CMD_RAW: begin
              mode_next  = MODE_RAW;
              state_next = S_ADV_M3;
            end
            CMD_RANGE: begin
              if (stat.hi_eq_lo) begin
                res_sel_next = RES_LOW;
                state_next   = S_FINISH;
              end else if (stat.hi_lt_lo) begin
                res_sel_next = RES_ERR;
                state_next   = S_FINISH;
              end else begin
                mode_next    = MODE_RANGE;
                res_sel_next = RES_SCALED;
                state_next   = S_ADV_M3;
              end
            end
            default: begin
              state_next = S_FINISH;
            end
          endcase
        end
      end
      S_SEED_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_SEED;
        state_next  = S_SEED_WR;
      end
      S_SEED_WR: begin
        cmd.seed_wr = 1'b1;
        if (idx == IDX_W'(NUM_WORDS - 1)) begin
          state_next = S_ADV_M3;
        end else begin
          idx_next   = idx + IDX_W'(1);
          state_next = S_SEED_MUL;
        end
      end
      S_ADV_M3: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = MUL_W3;
        cmd.acc_init = 1'b1;
        state_next   = S_ADV_M2;
      end
      S_ADV_M2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_W2;
        cmd.acc_add = 1'b1;
        state_next  = S_ADV_M1;
      end
      S_ADV_M1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_W1;
        cmd.acc_add = 1'b1;
        state_next  = S_ADV_M0;
      end
      S_ADV_M0: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_W0;
        cmd.acc_add = 1'b1;
        state_next  = S_ADV_COMMIT;
      end
      S_ADV_COMMIT: begin
        cmd.advance = 1'b1;
        case (mode)
          MODE_SEED: begin
            if (disc == DISC_W'(DISCARDS - 1)) begin
              boot_next  = 1'b0;
              state_next = boot ? S_IDLE : S_FINISH;
            end else begin
              disc_next  = disc + DISC_W'(1);
              state_next = S_ADV_M3;
            end
          end
          MODE_RANGE: state_next = S_RNG_MUL;
          default:    state_next = S_FINISH;
        endcase
      end
      S_RNG_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_RANGE;
        state_next  = S_FINISH;
      end
      S_FINISH: begin
        if (stat.out_room) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    idx <= IDX_W'(NUM_WORDS - 1))
    else $error("seed index past last word");

  a_disc_range: assert property (@(posedge clk) disable iff (rst)
    disc <= DISC_W'(DISCARDS - 1))
    else $error("discard count past limit");

  a_raw_starts_advance: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && in_valid && stat.command == CMD_RAW) |=> state == S_ADV_M3)
    else $error("raw command did not start an advance");

endmodule

// File: hdl/moap_dp.sv
// Datapath of the generator: history and carry words, shared multiplier,
// accumulator and output register. Depends on moap_pkg, moap_req_if, moap_rsp_if.
module moap_dp (
  input  logic              clk,
  input  logic              rst,
  moap_req_if.sink          req,
  moap_rsp_if.source        rsp,
  input  moap_pkg::dp_cmd_t cmd,
  output moap_pkg::dp_stat_t stat
);
  import moap_pkg::*;

  logic [WORD_W-1:0]        words [NUM_WORDS];
  logic [WORD_W-1:0]        seed;
  logic [WORD_W-1:0]        seed_next;
  logic signed [WORD_W-1:0] low;
  logic [WORD_W-1:0]        interval;
  logic [2*WORD_W-1:0]      prod;
  logic [2*WORD_W-1:0]      acc;
  logic [2*WORD_W-1:0]      sum;
  logic [WORD_W-1:0]        mul_a;
  logic [WORD_W-1:0]        mul_b;
  logic signed [WORD_W-1:0] ranged_next;
  logic                     out_valid;

  assign stat.command  = req.command;
  assign stat.hi_eq_lo = req.range_high == req.range_low;
  assign stat.hi_lt_lo = req.range_high < req.range_low;
  assign stat.out_room = !out_valid || rsp.ready;

  always_comb begin
    case (cmd.mul_sel)
      MUL_W3:    begin mul_a = MWC_A3;   mul_b = words[3]; end
      MUL_W2:    begin mul_a = MWC_A2;   mul_b = words[2]; end
      MUL_W1:    begin mul_a = MWC_A1;   mul_b = words[1]; end
      MUL_W0:    begin mul_a = MWC_A0;   mul_b = words[0]; end
      MUL_SEED:  begin mul_a = SEED_MULT; mul_b = seed;    end
      MUL_RANGE: begin mul_a = interval; mul_b = words[0]; end
      default:   begin mul_a = '0;       mul_b = '0;       end
    endcase
  end

  assign sum       = acc + prod;
  assign seed_next = prod[WORD_W-1:0] - WORD_W'(1);

  always_comb begin
    case (cmd.res_sel)
      RES_LOW:    ranged_next = low;
      RES_ERR:    ranged_next = RANGE_ERR_VALUE;
      RES_SCALED: ranged_next = low + $signed(prod[2*WORD_W-1:WORD_W]);
      default:    ranged_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      low      <= req.range_low;
      interval <= $unsigned(req.range_high) - $unsigned(req.range_low);
      seed     <= $unsigned(req.seed_value);
    end else if (cmd.seed_clr) begin
      seed <= '0;
    end else if (cmd.seed_wr) begin
      seed <= seed_next;
    end
    if (cmd.mul_en) begin
      prod <= (2*WORD_W)'(mul_a) * (2*WORD_W)'(mul_b);
    end
    if (cmd.acc_init) begin
      acc <= {{WORD_W{1'b0}}, words[CARRY_IDX]};
    end else if (cmd.acc_add) begin
      acc <= sum;
    end
    if (cmd.seed_wr) begin
      words[cmd.seed_idx] <= seed_next;
    end else if (cmd.advance) begin
      words[3]         <= words[2];
      words[2]         <= words[1];
      words[1]         <= words[0];
      words[0]         <= sum[WORD_W-1:0];
      words[CARRY_IDX] <= sum[2*WORD_W-1:WORD_W];
    end
    if (cmd.out_load) begin
      rsp.raw_word     <= words[0];
      rsp.ranged_value <= ranged_next;
      rsp.range_error  <= cmd.res_sel == RES_ERR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign rsp.valid = out_valid;

  a_load_has_room: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> stat.out_room)
    else $error("output word overwritten before it was taken");

  a_err_value: assert property (@(posedge clk) disable iff (rst)
    (out_valid && rsp.range_error) |-> rsp.ranged_value == RANGE_ERR_VALUE)
    else $error("range error without minimum value");

  a_single_op: assert property (@(posedge clk) disable iff (rst)
    !(cmd.seed_wr && cmd.advance))
    else $error("seed write and advance in one cycle");

endmodule

// File: test/moap_draw_checker.sv
`timescale 1ns / 100ps
// Draw checker for the multiply-with-carry generator: watches request and
// response words, predicts each response and compares it field by field.
// Depends on moap_pkg, moap_req_if and moap_rsp_if.
module moap_draw_checker (
  input  logic clk,
  input  logic rst,
  moap_req_if  req,
  moap_rsp_if  rsp,
  output int   fail_count,
  output int   pending
);
  import moap_pkg::*;

  typedef struct packed {
    logic [WORD_W-1:0]        raw_word;
    logic signed [WORD_W-1:0] ranged_value;
    logic                     range_error;
  } draw_t;

  logic [WORD_W-1:0] mwc_words [NUM_WORDS];
  draw_t             expected_draws [$];
  draw_t             want;
  draw_t             got;

  function automatic logic [WORD_W-1:0] mwc_advance();
    logic [63:0] acc;
    acc = {32'b0, MWC_A3} * {32'b0, mwc_words[3]}
        + {32'b0, MWC_A2} * {32'b0, mwc_words[2]}
        + {32'b0, MWC_A1} * {32'b0, mwc_words[1]}
        + {32'b0, MWC_A0} * {32'b0, mwc_words[0]}
        + {32'b0, mwc_words[CARRY_IDX]};
    mwc_words[3]         = mwc_words[2];
    mwc_words[2]         = mwc_words[1];
    mwc_words[1]         = mwc_words[0];
    mwc_words[CARRY_IDX] = acc[63:32];
    mwc_words[0]         = acc[31:0];
    return acc[31:0];
  endfunction

  function automatic void mwc_reseed(input logic [WORD_W-1:0] seed);
    logic [WORD_W-1:0] chain;
    logic [WORD_W-1:0] dropped;
    chain = seed;
    for (int i = 0; i < NUM_WORDS; i++) begin
      chain = chain * SEED_MULT - 32'd1;
      mwc_words[i] = chain;
    end
    for (int i = 0; i < DISCARDS; i++) begin
      dropped = mwc_advance();
    end
  endfunction

  function automatic draw_t predict_draw(input logic [1:0] cmd,
                                         input logic [WORD_W-1:0] seed,
                                         input logic signed [WORD_W-1:0] lo,
                                         input logic signed [WORD_W-1:0] hi);
    draw_t             d;
    logic [WORD_W-1:0] span;
    logic [WORD_W-1:0] w;
    logic [63:0]       prod;
    d = '0;
    case (cmd)
      CMD_SEED: mwc_reseed(seed);
      CMD_RAW: w = mwc_advance();
      CMD_RANGE: begin
        if (hi == lo) begin
          d.ranged_value = lo;
        end else if (hi < lo) begin
          d.ranged_value = RANGE_ERR_VALUE;
          d.range_error  = 1'b1;
        end else begin
          span = hi - lo;
          w    = mwc_advance();
          prod = {32'b0, span} * {32'b0, w};
          d.ranged_value = lo + prod[63:32];
        end
      end
      default: ;
    endcase
    d.raw_word = mwc_words[0];
    return d;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      mwc_reseed('0);
      expected_draws.delete();
      fail_count = 0;
      pending <= 0;
    end else begin
      // retire first: a response never belongs to the word accepted this edge
      if (rsp.valid && rsp.ready) begin
        got = {rsp.raw_word, rsp.ranged_value, rsp.range_error};
        if (expected_draws.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: response with nothing expected: raw %h ranged %h err %b",
                     $time, got.raw_word, got.ranged_value, got.range_error);
        end else begin
          want = expected_draws.pop_front();
          if (got != want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: mismatch raw %h/%h ranged %h/%h err %b/%b (exp/act)",
                       $time, want.raw_word, got.raw_word, want.ranged_value,
                       got.ranged_value, want.range_error, got.range_error);
          end
        end
      end
      if (req.valid && req.ready)
        expected_draws.push_back(predict_draw(req.command, req.seed_value,
                                              req.range_low, req.range_high));
      pending <= expected_draws.size();
    end
  end
endmodule

// File: test/mother_of_all_prng_with_range_core_tb.sv
`timescale 1ns / 100ps
// Testbench top for the multiply-with-carry generator: drives command words,
// throttles responses and gives the verdict from the draw checker.
// Depends on moap_pkg, the channel interfaces, the core and moap_draw_checker.
module mother_of_all_prng_with_range_core_tb;
  import moap_pkg::*;

  localparam logic [1:0] CMD_NONE     = 2'd3;
  localparam int         RANDOM_WORDS = 1750;
  localparam int         HOLD_CYCLES  = 300;
  localparam int         IDLE_LIMIT   = 5000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   pending;
  bit   quiet;
  bit   hold_req;
  int   idle_cycles;

  moap_req_if req_ch ();
  moap_rsp_if rsp_ch ();

  mother_of_all_prng_with_range_core u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  moap_draw_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic send_word(input logic [1:0] cmd, input logic [31:0] seed,
                           input logic [31:0] lo, input logic [31:0] hi);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.command    <= cmd;
    req_ch.seed_value <= seed;
    req_ch.range_low  <= lo;
    req_ch.range_high <= hi;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  task automatic send_random_word();
    int          pick;
    logic [1:0]  cmd;
    logic [31:0] seed;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] tmp;
    pick = $urandom_range(0, 99);
    seed = $urandom;
    lo   = $urandom;
    hi   = $urandom;
    if (pick < 5) begin
      cmd = CMD_SEED;
    end else if (pick < 45) begin
      cmd = CMD_RAW;
    end else if (pick < 97) begin
      cmd = CMD_RANGE;
      case ($urandom_range(0, 4))
        0: ;
        1: hi = lo + $urandom_range(1, 1000);
        2: hi = lo;
        3: hi = lo - $urandom_range(1, 1000);
        default: begin
          if ($signed(hi) < $signed(lo)) begin
            tmp = lo;
            lo  = hi;
            hi  = tmp;
          end
        end
      endcase
    end else begin
      cmd = CMD_NONE;
    end
    send_word(cmd, seed, lo, hi);
  endtask

  // drain response channel
  initial begin
    int stall;
    rsp_ch.ready <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        rsp_ch.ready <= 1'b0;
        hold_req = 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      stall = quiet ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_ch.valid) @(posedge clk);
    end
  end

  // watchdog: no word moving on either channel for too long
  initial begin
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    req_ch.valid      <= 1'b0;
    req_ch.command    <= CMD_SEED;
    req_ch.seed_value <= '0;
    req_ch.range_low  <= '0;
    req_ch.range_high <= '0;
    quiet    = 1'b0;
    hold_req = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    send_word(CMD_RAW,   32'h0,         32'h0,         32'h0);
    send_word(CMD_RAW,   32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_word(CMD_RANGE, 32'h0,         32'd0,         32'd10);
    send_word(CMD_RANGE, 32'h0,         32'h8000_0000, 32'h7fff_ffff);
    send_word(CMD_RANGE, 32'h0,         32'h7fff_ffff, 32'h7fff_ffff);
    send_word(CMD_RANGE, 32'h0,         32'h8000_0000, 32'h8000_0000);
    send_word(CMD_RANGE, 32'h0,         32'h7fff_ffff, 32'h8000_0000);
    send_word(CMD_RANGE, 32'h0,         -32'sd5,       -32'sd6);
    send_word(CMD_RANGE, 32'h0,         32'h8000_0000, 32'h8000_0001);
    send_word(CMD_RANGE, 32'h0,         32'h7fff_fffe, 32'h7fff_ffff);
    send_word(CMD_RANGE, 32'h0,         -32'sd100,     32'sd100);
    send_word(CMD_NONE,  32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_word(CMD_SEED,  32'hffff_ffff, 32'h0,         32'h0);
    send_word(CMD_RAW,   32'h0,         32'h0,         32'h0);
    send_word(CMD_SEED,  32'h8000_0000, 32'h0,         32'h0);
    send_word(CMD_RANGE, 32'h0,         32'd0,         32'd1);
    send_word(CMD_SEED,  32'h7fff_ffff, 32'h0,         32'h0);
    send_word(CMD_RANGE, 32'h0,         32'd0,         32'h7fff_ffff);
    send_word(CMD_SEED,  32'h0,         32'h0,         32'h0);
    send_word(CMD_RAW,   32'h0,         32'h0,         32'h0);
    send_word(CMD_NONE,  32'h0,         32'h0,         32'h0);

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 250 == 0)
        quiet = ($urandom_range(0, 3) == 0);
      if (n == 500)
        hold_req = 1'b1;
      if (n == 1000 || n == 1500) begin
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
      end
      send_random_word();
    end

    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end
endmodule

// File: mother_of_all_prng_with_range_core.f
hdl/moap_pkg.sv
hdl/moap_req_if.sv
hdl/moap_rsp_if.sv
hdl/moap_ctrl.sv
hdl/moap_dp.sv
hdl/mother_of_all_prng_with_range_core.sv
test/moap_draw_checker.sv
test/mother_of_all_prng_with_range_core_tb.sv
